>>> rtl/ple_pkg.sv
package ple_pkg;

  localparam int CMD_W   = 1;
  localparam int POS_W   = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 1'b0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value_in;
  } ple_in_t;

  typedef struct packed {
    logic                     ok;
    logic [COUNT_W-1:0]       entry_count;
    logic                     list_empty;
    logic signed [WORD_W-1:0] last_value;
  } ple_out_t;

endpackage

>>> rtl/positional_list_editor.sv
// Channel  | Ports                          | Moves
// ---------+--------------------------------+---------------------------------------
// request  | in_valid, in_ready, in_req     | cmd, position, value_in
// response | out_valid, out_ready, out_rsp  | ok, entry_count, list_empty, last_value
//
// Sequence: one request per pass. An insert at p moves entries p..n back and
//   writes the new word, a remove moves p+1..n forward, a refused one moves
//   none; the pace is set by the entry memory, which moves one word per cycle.
// Reset: rst_n low (synchronous) empties the list; memory contents are kept.
// Stalls: in_ready is high only between requests; a finished response sits in
//   the output register while the next request is taken and worked on.
module positional_list_editor #(
  parameter int CAPACITY = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ple_pkg::ple_in_t  in_req,
  output logic              out_valid,
  input  logic              out_ready,
  output ple_pkg::ple_out_t out_rsp
);

  localparam int AW = $clog2(CAPACITY);      // memory address width
  localparam int CW = $clog2(CAPACITY + 1);  // entry count width
  localparam int PW = 9;                     // compare width: position vs count+1

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MOVE = 6'b000010,
    S_PUT  = 6'b000100,
    S_TAIL = 6'b001000,
    S_LAST = 6'b010000,
    S_HOLD = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] moves_r, moves_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          pend_r, pend_nxt;
  logic          is_ins_r, is_ins_nxt;
  logic          ok_r, ok_nxt;
  logic [AW-1:0] put_addr_r, put_addr_nxt;
  logic signed [ple_pkg::WORD_W-1:0] word_r, word_nxt;
  logic          out_valid_r, out_valid_nxt;
  ple_pkg::ple_out_t out_r, out_nxt;

  // Entry memory: one write port, one registered read port
  logic signed [ple_pkg::WORD_W-1:0] mem [CAPACITY];
  logic signed [ple_pkg::WORD_W-1:0] rdata_r;
  logic [AW-1:0]                     rd_addr;
  logic                              wr_en;
  logic [AW-1:0]                     wr_addr;
  logic signed [ple_pkg::WORD_W-1:0] wr_data;

  logic [PW-1:0] n9, p9;
  logic          ins_ok, rem_ok, req_ok;
  logic [CW+4:0] count_ext;
  logic          out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // Admission checks against the current count
  assign n9     = PW'(count_r);
  assign p9     = PW'(in_req.position);
  assign ins_ok = (p9 != '0) && (p9 <= n9 + PW'(1)) && (count_r != CW'(CAPACITY));
  assign rem_ok = (p9 != '0) && (p9 <= n9);
  assign req_ok = (in_req.cmd == ple_pkg::CMD_INSERT) ? ins_ok : rem_ok;

  // count is reported modulo 32
  assign count_ext = {5'b0, count_r};

  // Read port: shift source while moving, tail entry from S_TAIL until the
  // response is handed over (refreshed every cycle while it waits)
  assign rd_addr = (state_r == S_TAIL || state_r == S_LAST || state_r == S_HOLD) ?
                   AW'(count_r - CW'(1)) : rd_ptr_r;

  // Write port: pending shift write, or the inserted word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_addr_r;
    wr_data = rdata_r;
    if (state_r == S_MOVE && pend_r) begin
      wr_en = 1'b1;
    end else if (state_r == S_PUT) begin
      wr_en   = 1'b1;
      wr_addr = put_addr_r;
      wr_data = word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    moves_nxt     = moves_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_addr_nxt   = wr_addr_r;
    pend_nxt      = 1'b0;
    is_ins_nxt    = is_ins_r;
    ok_nxt        = ok_r;
    put_addr_nxt  = put_addr_r;
    word_nxt      = word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          is_ins_nxt   = (in_req.cmd == ple_pkg::CMD_INSERT);
          ok_nxt       = req_ok;
          word_nxt     = in_req.value_in;
          put_addr_nxt = AW'(p9 - PW'(1));
          if (in_req.cmd == ple_pkg::CMD_INSERT) begin
            // entries p-1..n-1 move back, walking from the end
            moves_nxt  = CW'(n9 - p9 + PW'(1));
            rd_ptr_nxt = AW'(n9 - PW'(1));
          end else begin
            // entries p..n-1 move forward
            moves_nxt  = CW'(n9 - p9);
            rd_ptr_nxt = AW'(p9);
          end
          if (req_ok) begin
            count_nxt = (in_req.cmd == ple_pkg::CMD_INSERT) ? count_r + CW'(1)
                                                            : count_r - CW'(1);
            state_nxt = S_MOVE;
          end else begin
            state_nxt = S_TAIL;
          end
        end
      end
      S_MOVE: begin
        if (moves_r != '0) begin
          pend_nxt    = 1'b1;
          moves_nxt   = moves_r - CW'(1);
          wr_addr_nxt = is_ins_r ? rd_ptr_r + AW'(1) : rd_ptr_r - AW'(1);
          rd_ptr_nxt  = is_ins_r ? rd_ptr_r - AW'(1) : rd_ptr_r + AW'(1);
        end else begin
          // last pending write lands at this edge
          state_nxt = is_ins_r ? S_PUT : S_TAIL;
        end
      end
      S_PUT: begin
        state_nxt = S_TAIL;
      end
      S_TAIL: begin
        state_nxt = S_LAST;
      end
      S_LAST, S_HOLD: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_nxt.ok          = ok_r;
          out_nxt.entry_count = count_ext[4:0];
          out_nxt.list_empty  = (count_r == '0);
          out_nxt.last_value  = (count_r == '0) ? '0 : rdata_r;
          state_nxt           = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    moves_r    <= moves_nxt;
    wr_addr_r  <= wr_addr_nxt;
    is_ins_r   <= is_ins_nxt;
    ok_r       <= ok_nxt;
    put_addr_r <= put_addr_nxt;
    word_r     <= word_nxt;
    out_r      <= out_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
  end

endmodule

>>> rtl/ple_checker.sv
module ple_checker #(
  parameter int CAPACITY = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input ple_pkg::ple_in_t  in_req,
  input logic              out_valid,
  input logic              out_ready,
  input ple_pkg::ple_out_t out_rsp
);

  localparam bit SMALL = (CAPACITY <= 31);

  // one request at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ple: in_ready high right after a request was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL |-> out_rsp.entry_count <= 5'(CAPACITY))
    else $error("ple: entry_count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL |-> out_rsp.list_empty == (out_rsp.entry_count == '0))
    else $error("ple: list_empty disagrees with entry_count");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.list_empty |-> out_rsp.last_value == '0)
    else $error("ple: empty list with nonzero last_value");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("ple: stalled response changed");

endmodule

bind positional_list_editor ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_rsp   (out_rsp)
);
